// ===== rtl/lc3_pkg.sv =====
// Package for the LC-3 instruction step block.
// Holds command and opcode codes, condition bits and the memory and register request structs.
// No dependencies.
`default_nettype none
package lc3_pkg;

   localparam logic [1:0] CMD_MEM_WR = 2'd0;
   localparam logic [1:0] CMD_REG_WR = 2'd1;
   localparam logic [1:0] CMD_STEP   = 2'd2;

   localparam logic [3:0] OP_BR   = 4'h0;
   localparam logic [3:0] OP_ADD  = 4'h1;
   localparam logic [3:0] OP_LD   = 4'h2;
   localparam logic [3:0] OP_ST   = 4'h3;
   localparam logic [3:0] OP_JSR  = 4'h4;
   localparam logic [3:0] OP_AND  = 4'h5;
   localparam logic [3:0] OP_LDR  = 4'h6;
   localparam logic [3:0] OP_STR  = 4'h7;
   localparam logic [3:0] OP_NOT  = 4'h9;
   localparam logic [3:0] OP_LDI  = 4'hA;
   localparam logic [3:0] OP_STI  = 4'hB;
   localparam logic [3:0] OP_JMP  = 4'hC;
   localparam logic [3:0] OP_LEA  = 4'hE;
   localparam logic [3:0] OP_TRAP = 4'hF;

   localparam logic [2:0] CC_N = 3'b100;
   localparam logic [2:0] CC_Z = 3'b010;
   localparam logic [2:0] CC_P = 3'b001;

   localparam logic [7:0]  TRAP_HALT   = 8'h25;
   localparam logic [15:0] START_RESET = 16'h3000;
   localparam int          REG_COUNT   = 8;

   typedef struct packed {
      logic        we;
      logic        re;
      logic [15:0] addr;
      logic [15:0] wdata;
   } mem_req_type;

   typedef struct packed {
      logic        we;
      logic [2:0]  waddr;
      logic [15:0] wdata;
      logic        re;
      logic [2:0]  raddr_a;
      logic [2:0]  raddr_b;
   } reg_req_type;

   function automatic logic [2:0] cc_of(input logic [15:0] value);
      logic [2:0] cc;
      if (value == 16'd0) begin
         cc = CC_Z;
      end else if (value[15]) begin
         cc = CC_N;
      end else begin
         cc = CC_P;
      end
      return cc;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/lc3_chan_if.sv =====
// Valid/ready channel interfaces of the LC-3 instruction step block.
// Request, response and register-write channels; no dependencies.
`default_nettype none
interface lc3_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] addr;
   logic [15:0] data;
   modport source (output valid, cmd, addr, data, input ready);
   modport sink   (input valid, cmd, addr, data, output ready);
endinterface

interface lc3_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] next_pc;
   logic [15:0] executed_word;
   logic [2:0]  cond_code;
   logic        halted;
   modport source (output valid, next_pc, executed_word, cond_code, halted, input ready);
   modport sink   (input valid, next_pc, executed_word, cond_code, halted, output ready);
endinterface

interface lc3_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/lc3_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module lc3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== rtl/lc3_ctrl.sv =====
// Sequencer and datapath of the LC-3 instruction step block.
// Uses lc3_pkg and the channel interfaces; drives main memory and register file RAMs.
`default_nettype none
module lc3_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   lc3_req_if.sink             req_bus,
   lc3_rsp_if.source           rsp_bus,
   lc3_csr_if.sink             csr_bus,
   output lc3_pkg::mem_req_type mem_req,
   input  wire logic [15:0]    mem_rdata,
   output lc3_pkg::reg_req_type reg_req,
   input  wire logic [15:0]    reg_rdata_a,
   input  wire logic [15:0]    reg_rdata_b
);
   import lc3_pkg::*;

   typedef enum logic [1:0] {S_START, S_DECODE, S_EXEC, S_WBACK} state_type;

   state_type   state_ff, state_in;
   logic        item_valid_ff, item_valid_in;
   logic [1:0]  item_cmd_ff, item_cmd_in;
   logic [15:0] item_addr_ff, item_addr_in;
   logic [15:0] item_data_ff, item_data_in;
   logic [15:0] pc_ff, pc_in;
   logic [2:0]  cc_ff, cc_in;
   logic [15:0] word_ff, word_in;
   logic [7:0]  reg_vld_ff, reg_vld_in;
   logic        vld_a_ff, vld_a_in;
   logic        vld_b_ff, vld_b_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_pc_ff, rsp_pc_in;
   logic [15:0] rsp_word_ff, rsp_word_in;
   logic [2:0]  rsp_cc_ff, rsp_cc_in;
   logic        rsp_halted_ff, rsp_halted_in;

   logic        out_free;
   logic        consume;
   logic        finish;
   logic        step_done;
   logic [15:0] w_cur;
   logic [3:0]  opcode;
   logic [2:0]  dr;
   logic [2:0]  sr1;
   logic [2:0]  rb_addr;
   logic [15:0] off9;
   logic [15:0] off11;
   logic [15:0] base6;
   logic [15:0] ra;
   logic [15:0] rb;
   logic [15:0] alu_b;
   logic        step_halt;

   assign out_free = ~rsp_valid_ff | rsp_bus.ready;
   assign w_cur    = (state_ff == S_DECODE) ? mem_rdata : word_ff;
   assign opcode   = w_cur[15:12];
   assign dr       = w_cur[11:9];
   assign sr1      = w_cur[8:6];
   assign rb_addr  = (opcode == OP_ST || opcode == OP_STI || opcode == OP_STR) ? dr : w_cur[2:0];
   assign off9     = pc_ff + {{7{w_cur[8]}}, w_cur[8:0]};
   assign off11    = pc_ff + {{5{w_cur[10]}}, w_cur[10:0]};
   assign ra       = vld_a_ff ? reg_rdata_a : 16'd0;
   assign rb       = vld_b_ff ? reg_rdata_b : 16'd0;
   assign base6    = ra + {{10{w_cur[5]}}, w_cur[5:0]};
   assign alu_b    = w_cur[5] ? {{11{w_cur[4]}}, w_cur[4:0]} : rb;
   assign step_halt = (word_ff == 16'd0);

   assign req_bus.ready = ~item_valid_ff | consume;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.next_pc       = rsp_pc_ff;
   assign rsp_bus.executed_word = rsp_word_ff;
   assign rsp_bus.cond_code     = rsp_cc_ff;
   assign rsp_bus.halted        = rsp_halted_ff;

   always_comb begin
      state_in      = state_ff;
      item_valid_in = item_valid_ff;
      item_cmd_in   = item_cmd_ff;
      item_addr_in  = item_addr_ff;
      item_data_in  = item_data_ff;
      pc_in         = pc_ff;
      cc_in         = cc_ff;
      word_in       = word_ff;
      reg_vld_in    = reg_vld_ff;
      vld_a_in      = vld_a_ff;
      vld_b_in      = vld_b_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_pc_in     = rsp_pc_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_cc_in     = rsp_cc_ff;
      rsp_halted_in = rsp_halted_ff;
      mem_req       = '0;
      reg_req       = '0;
      consume       = 1'b0;
      finish        = 1'b0;
      step_done     = 1'b0;

      case (state_ff)
         S_START: begin
            if (item_valid_ff) begin
               case (item_cmd_ff)
                  CMD_STEP: begin
                     mem_req.re   = 1'b1;
                     mem_req.addr = pc_ff;
                     pc_in        = pc_ff + 16'd1;
                     consume      = 1'b1;
                     state_in     = S_DECODE;
                  end
                  CMD_MEM_WR: begin
                     if (out_free) begin
                        mem_req.we    = 1'b1;
                        mem_req.addr  = item_addr_ff;
                        mem_req.wdata = item_data_ff;
                        consume       = 1'b1;
                        finish        = 1'b1;
                     end
                  end
                  CMD_REG_WR: begin
                     if (out_free) begin
                        reg_req.we    = (item_addr_ff[15:3] == 13'd0);
                        reg_req.waddr = item_addr_ff[2:0];
                        reg_req.wdata = item_data_ff;
                        consume       = 1'b1;
                        finish        = 1'b1;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        consume = 1'b1;
                        finish  = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_DECODE: begin
            word_in         = mem_rdata;
            reg_req.re      = 1'b1;
            reg_req.raddr_a = sr1;
            reg_req.raddr_b = rb_addr;
            vld_a_in        = reg_vld_ff[sr1];
            vld_b_in        = reg_vld_ff[rb_addr];
            if (opcode == OP_LD || opcode == OP_LDI || opcode == OP_STI) begin
               mem_req.re   = 1'b1;
               mem_req.addr = off9;
            end
            state_in = S_EXEC;
         end
         S_EXEC: begin
            case (opcode)
               OP_LDR: begin
                  mem_req.re   = 1'b1;
                  mem_req.addr = base6;
                  state_in     = S_WBACK;
               end
               OP_LDI: begin
                  mem_req.re   = 1'b1;
                  mem_req.addr = mem_rdata;
                  state_in     = S_WBACK;
               end
               default: begin
                  if (out_free) begin
                     finish    = 1'b1;
                     step_done = 1'b1;
                     state_in  = S_START;
                     case (opcode)
                        OP_BR: begin
                           if ((dr & cc_ff) != 3'd0) begin
                              pc_in = off9;
                           end
                        end
                        OP_ADD, OP_AND, OP_NOT: begin
                           reg_req.we    = 1'b1;
                           reg_req.waddr = dr;
                           if (opcode == OP_ADD) begin
                              reg_req.wdata = ra + alu_b;
                           end else if (opcode == OP_AND) begin
                              reg_req.wdata = ra & alu_b;
                           end else begin
                              reg_req.wdata = ~ra;
                           end
                           cc_in = cc_of(reg_req.wdata);
                        end
                        OP_LD: begin
                           reg_req.we    = 1'b1;
                           reg_req.waddr = dr;
                           reg_req.wdata = mem_rdata;
                           cc_in         = cc_of(mem_rdata);
                        end
                        OP_ST: begin
                           mem_req.we    = 1'b1;
                           mem_req.addr  = off9;
                           mem_req.wdata = rb;
                        end
                        OP_STR: begin
                           mem_req.we    = 1'b1;
                           mem_req.addr  = base6;
                           mem_req.wdata = rb;
                        end
                        OP_STI: begin
                           mem_req.we    = 1'b1;
                           mem_req.addr  = mem_rdata;
                           mem_req.wdata = rb;
                        end
                        OP_JSR: begin
                           pc_in         = w_cur[11] ? off11 : ra;
                           reg_req.we    = 1'b1;
                           reg_req.waddr = 3'd7;
                           reg_req.wdata = pc_ff;
                        end
                        OP_JMP: begin
                           pc_in = ra;
                        end
                        OP_LEA: begin
                           reg_req.we    = 1'b1;
                           reg_req.waddr = dr;
                           reg_req.wdata = off9;
                        end
                        OP_TRAP: begin
                           if (w_cur[7:0] == TRAP_HALT) begin
                              pc_in = 16'd0;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            endcase
         end
         S_WBACK: begin
            if (out_free) begin
               reg_req.we    = 1'b1;
               reg_req.waddr = dr;
               reg_req.wdata = mem_rdata;
               cc_in         = cc_of(mem_rdata);
               finish        = 1'b1;
               step_done     = 1'b1;
               state_in      = S_START;
            end
         end
         default: begin
            state_in = S_START;
         end
      endcase

      if (reg_req.we) begin
         reg_vld_in[reg_req.waddr] = 1'b1;
      end

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
         if (step_done) begin
            rsp_pc_in     = step_halt ? 16'd0 : pc_in;
            rsp_word_in   = word_ff;
            rsp_cc_in     = cc_in;
            rsp_halted_in = step_halt;
         end else begin
            rsp_pc_in     = pc_ff;
            rsp_word_in   = 16'd0;
            rsp_cc_in     = cc_ff;
            rsp_halted_in = 1'b0;
         end
      end

      if (req_bus.valid && req_bus.ready) begin
         item_valid_in = 1'b1;
         item_cmd_in   = req_bus.cmd;
         item_addr_in  = req_bus.addr;
         item_data_in  = req_bus.data;
      end else if (consume) begin
         item_valid_in = 1'b0;
      end

      if (csr_bus.valid) begin
         pc_in = csr_bus.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_START;
         item_valid_ff <= 1'b0;
         pc_ff         <= START_RESET;
         cc_ff         <= 3'd0;
         reg_vld_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         item_valid_ff <= item_valid_in;
         pc_ff         <= pc_in;
         cc_ff         <= cc_in;
         reg_vld_ff    <= reg_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_cmd_ff   <= item_cmd_in;
      item_addr_ff  <= item_addr_in;
      item_data_ff  <= item_data_in;
      word_ff       <= word_in;
      vld_a_ff      <= vld_a_in;
      vld_b_ff      <= vld_b_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_cc_ff     <= rsp_cc_in;
      rsp_halted_ff <= rsp_halted_in;
   end
endmodule
`default_nettype wire

// ===== rtl/lc3_instruction_step.sv =====
// Top level of the LC-3 instruction step block.
// Uses lc3_pkg, the channel interfaces, lc3_ctrl and lc3_ram.
//
//   channel   dir  payload                                       transaction
//   req_bus   in   cmd, addr, data                               valid & ready
//   rsp_bus   out  next_pc, executed_word, cond_code, halted     valid & ready
//   csr_bus   in   data (start address, also loads the PC)       valid & ready
//
// A step runs fetch, decode, execute, and write-back for LDR and LDI; the single
// port of main memory carries the fetch, the data access and the indirect access.
// Memory and register writes end in the start state. One transaction waits in an
// input register while another is at work. Reset loads the PC with 0x3000 and
// clears the condition bits; registers read as zero until written, with no sweep.
// A stalled response holds the last cycle of the transaction that follows it.
`default_nettype none
module lc3_instruction_step #(
   parameter int ADDR_BITS = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   lc3_req_if.sink   req_bus,
   lc3_rsp_if.source rsp_bus,
   lc3_csr_if.sink   csr_bus
);
   import lc3_pkg::*;

   mem_req_type mem_req;
   reg_req_type reg_req;
   logic [15:0] mem_rdata;
   logic [15:0] reg_rdata_a;
   logic [15:0] reg_rdata_b;
   logic [ADDR_BITS-1:0] mem_addr;

   assign mem_addr = mem_req.addr[ADDR_BITS-1:0];

   lc3_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus),
      .mem_req     (mem_req),
      .mem_rdata   (mem_rdata),
      .reg_req     (reg_req),
      .reg_rdata_a (reg_rdata_a),
      .reg_rdata_b (reg_rdata_b)
   );

   lc3_ram #(.WIDTH(16), .DEPTH(2 ** ADDR_BITS)) u_main_mem (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_addr),
      .wdata (mem_req.wdata),
      .re    (mem_req.re),
      .raddr (mem_addr),
      .rdata (mem_rdata)
   );

   lc3_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_regs_a (
      .clock (clock),
      .we    (reg_req.we),
      .waddr (reg_req.waddr),
      .wdata (reg_req.wdata),
      .re    (reg_req.re),
      .raddr (reg_req.raddr_a),
      .rdata (reg_rdata_a)
   );

   lc3_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_regs_b (
      .clock (clock),
      .we    (reg_req.we),
      .waddr (reg_req.waddr),
      .wdata (reg_req.wdata),
      .re    (reg_req.re),
      .raddr (reg_req.raddr_b),
      .rdata (reg_rdata_b)
   );
endmodule
`default_nettype wire

// ===== verif/tb_lc3_instruction_step.sv =====
`timescale 1ns / 100ps
// Testbench for lc3_instruction_step: random LC-3 programs with directed corner cases,
// random idling on req_bus and rsp_bus and a scoreboard that predicts each response.
// Depends on lc3_pkg, the channel interfaces in lc3_chan_if.sv and the block's RTL.
module tb_lc3_instruction_step;
   import lc3_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [15:0] next_pc;
      logic [15:0] executed_word;
      logic [2:0]  cond_code;
      logic        halted;
   } step_result_type;

   class lc3_scoreboard_type;
      logic [15:0]     memory_words [logic [15:0]];
      logic [15:0]     gpr [8];
      logic [15:0]     pc;
      logic [15:0]     start_addr;
      logic [2:0]      cc;
      step_result_type pending_results [$];
      int              errors;
      int              checked;
      int              steps;
      int              halts;

      function new();
         memory_words.delete();
         foreach (gpr[i]) gpr[i] = 16'h0000;
         start_addr = START_RESET;
         pc = start_addr;
         cc = 3'b000;
         errors = 0;
         checked = 0;
         steps = 0;
         halts = 0;
      endfunction

      function void load_start(input logic [15:0] value);
         start_addr = value;
         pc = value;
      endfunction

      function logic [15:0] fetch(input logic [15:0] a);
         return memory_words.exists(a) ? memory_words[a] : 16'h0000;
      endfunction

      function void write_gpr(input logic [2:0] dr, input logic [15:0] value,
                              input bit sets_cc);
         gpr[dr] = value;
         if (sets_cc) begin
            cc = (value == 16'h0000) ? CC_Z : (value[15] ? CC_N : CC_P);
         end
      endfunction

      function void execute(input logic [15:0] w);
         logic [2:0]  dr;
         logic [2:0]  sr1;
         logic [15:0] off9;
         logic [15:0] off6;
         logic [15:0] operand;
         logic [15:0] ptr;
         logic [15:0] link;
         dr = w[11:9];
         sr1 = w[8:6];
         off9 = pc + {{7{w[8]}}, w[8:0]};
         off6 = {{10{w[5]}}, w[5:0]};
         operand = w[5] ? {{11{w[4]}}, w[4:0]} : gpr[w[2:0]];
         case (w[15:12])
            OP_BR: begin
               if ((dr & cc) != 3'b000) pc = off9;
            end
            OP_ADD: write_gpr(dr, gpr[sr1] + operand, 1'b1);
            OP_AND: write_gpr(dr, gpr[sr1] & operand, 1'b1);
            OP_LD: write_gpr(dr, fetch(off9), 1'b1);
            OP_ST: memory_words[off9] = gpr[dr];
            OP_JSR: begin
               link = pc;
               if (w[11]) pc = pc + {{5{w[10]}}, w[10:0]};
               else pc = gpr[sr1];
               gpr[7] = link;
            end
            OP_LDR: write_gpr(dr, fetch(gpr[sr1] + off6), 1'b1);
            OP_STR: memory_words[gpr[sr1] + off6] = gpr[dr];
            OP_NOT: write_gpr(dr, ~gpr[sr1], 1'b1);
            OP_LDI: begin
               ptr = fetch(off9);
               write_gpr(dr, fetch(ptr), 1'b1);
            end
            OP_STI: begin
               ptr = fetch(off9);
               memory_words[ptr] = gpr[dr];
            end
            OP_JMP: pc = gpr[sr1];
            OP_LEA: write_gpr(dr, off9, 1'b0);
            OP_TRAP: begin
               if (w[7:0] == TRAP_HALT) pc = 16'h0000;
            end
            default: ;
         endcase
      endfunction

      function void apply_command(input logic [1:0] cmd, input logic [15:0] addr,
                                  input logic [15:0] data);
         step_result_type r;
         logic [15:0]     word;
         bit              halt;
         word = 16'h0000;
         halt = 1'b0;
         case (cmd)
            CMD_MEM_WR: memory_words[addr] = data;
            CMD_REG_WR: begin
               if (addr < REG_COUNT) gpr[addr[2:0]] = data;
            end
            CMD_STEP: begin
               word = fetch(pc);
               pc = pc + 16'd1;
               execute(word);
               halt = (word == 16'h0000);
               steps++;
               if (halt) halts++;
            end
            default: ;
         endcase
         r.next_pc = halt ? 16'h0000 : pc;
         r.executed_word = word;
         r.cond_code = cc;
         r.halted = halt;
         pending_results.push_back(r);
      endfunction

      function void compare_result(input step_result_type got);
         step_result_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: response with none outstanding: next_pc %h word %h cc %b halted %b",
                     $time, got.next_pc, got.executed_word, got.cond_code, got.halted);
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got.next_pc !== want.next_pc) begin
            errors++;
            $display("%0t: next_pc expected %h actual %h", $time, want.next_pc, got.next_pc);
         end
         if (got.executed_word !== want.executed_word) begin
            errors++;
            $display("%0t: executed_word expected %h actual %h", $time,
                     want.executed_word, got.executed_word);
         end
         if (got.cond_code !== want.cond_code) begin
            errors++;
            $display("%0t: cond_code expected %b actual %b", $time,
                     want.cond_code, got.cond_code);
         end
         if (got.halted !== want.halted) begin
            errors++;
            $display("%0t: halted expected %b actual %b", $time, want.halted, got.halted);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   lc3_req_if req_bus ();
   lc3_rsp_if rsp_bus ();
   lc3_csr_if csr_bus ();

   lc3_instruction_step #(.ADDR_BITS(16)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   lc3_scoreboard_type sb = new();
   int                 sent = 0;
   int                 start_count = 0;
   bit                 req_calm = 1'b0;
   bit                 rsp_calm = 1'b0;

   always #1 clock = ~clock;

   function automatic int draw_gap(inout bit calm);
      if ($urandom_range(0, 31) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic logic [15:0] gen_word();
      logic [3:0]  op;
      logic [11:0] low;
      op = 4'($urandom_range(0, 15));
      low = 12'($urandom_range(0, 4095));
      if ($urandom_range(0, 24) == 0) return 16'h0000;
      if (op == OP_TRAP && $urandom_range(0, 1) == 1) low[7:0] = TRAP_HALT;
      return {op, low};
   endfunction

   function automatic logic [15:0] gen_data();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_req(input logic [1:0] cmd, input logic [15:0] addr,
                           input logic [15:0] data);
      int gap;
      gap = draw_gap(req_calm);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.addr <= addr;
      req_bus.data <= data;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.apply_command(cmd, addr, data);
      sent++;
   endtask

   task automatic drop_req();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_start(input logic [15:0] value);
      drop_req();
      wait_drained();
      repeat (6) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      sb.load_start(value);
      start_count++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic ensure_word(input logic [15:0] a, input bit as_code);
      if (!sb.memory_words.exists(a)) begin
         send_req(CMD_MEM_WR, a, as_code ? gen_word() : gen_data());
      end
   endtask

   // back every memory read of the coming step with a written word
   task automatic step_word();
      logic [15:0] w;
      logic [15:0] off9;
      ensure_word(sb.pc, 1'b1);
      w = sb.fetch(sb.pc);
      off9 = sb.pc + 16'd1 + {{7{w[8]}}, w[8:0]};
      case (w[15:12])
         OP_LD, OP_STI: ensure_word(off9, 1'b0);
         OP_LDI: begin
            ensure_word(off9, 1'b0);
            ensure_word(sb.fetch(off9), 1'b0);
         end
         OP_LDR: ensure_word(sb.gpr[w[8:6]] + {{10{w[5]}}, w[5:0]}, 1'b0);
         default: ;
      endcase
      send_req(CMD_STEP, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
   endtask

   task automatic run_word(input logic [15:0] w);
      send_req(CMD_MEM_WR, sb.pc, w);
      step_word();
   endtask

   task automatic random_item();
      int         pick;
      logic [1:0] cmd;
      pick = $urandom_range(0, 99);
      cmd = 2'($urandom_range(0, 3));
      if (pick < 6) begin
         if (cmd == CMD_STEP) step_word();
         else send_req(cmd, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end else if (pick < 14) begin
         send_req(CMD_REG_WR, 16'($urandom_range(0, 7)), gen_data());
      end else if (pick < 32) begin
         run_word(gen_word());
      end else begin
         step_word();
      end
   endtask

   initial begin
      step_result_type got;
      int              gap;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         gap = draw_gap(rsp_calm);
         @(negedge clock);
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got = {rsp_bus.next_pc, rsp_bus.executed_word, rsp_bus.cond_code, rsp_bus.halted};
         sb.compare_result(got);
      end
   end

   initial begin
      #400000;
      $display("%0t: timeout with %0d responses outstanding", $time,
               sb.pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [15:0] starts [4];
      int          target;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_MEM_WR;
      req_bus.addr = 16'h0000;
      req_bus.data = 16'h0000;
      csr_bus.valid = 1'b0;
      csr_bus.data = 16'h0000;
      starts[0] = 16'hFFFF;
      starts[1] = 16'h0000;
      starts[2] = 16'($urandom_range(0, 65535));
      starts[3] = START_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_req(CMD_REG_WR, 16'd1, 16'h7FFF);
      send_req(CMD_REG_WR, 16'd2, 16'h8000);
      send_req(CMD_REG_WR, 16'd7, 16'hFFFF);
      send_req(CMD_REG_WR, 16'd8, 16'h1234);
      send_req(CMD_REG_WR, 16'hFFFF, 16'hFFFF);
      send_req(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
      send_req(CMD_MEM_WR, 16'hFFFF, 16'hFFFF);
      // BRnzp with no condition bits set yet: must fall through
      run_word(16'h0E05);
      run_word(16'h0000);
      run_word(16'h1642);
      run_word(16'h1861);
      run_word(16'h5BE0);
      run_word(16'h9CBF);
      run_word({OP_TRAP, 4'h0, TRAP_HALT});
      run_word({OP_TRAP, 4'h0, 8'h23});

      foreach (starts[i]) begin
         write_start(starts[i]);
         target = sent + 100;
         while (sent < target) random_item();
      end

      drop_req();
      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d transactions, %0d of them instruction steps with %0d halts,",
               sent, sb.steps, sb.halts);
      $display("across %0d start addresses; %0d responses checked.",
               start_count + 1, sb.checked);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
